// ----- rtl/fcpu_pkg.sv -----
// ----------------------------------------------------------------------------
// fcpu_pkg
// shared types, constants and tables of the fly camera pose unit
// ----------------------------------------------------------------------------
`default_nettype none
package fcpu_pkg;
    localparam int FUNC_W = 2;
    localparam int DIR_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOK  = 2'd2;

    localparam logic [DIR_W-1:0] DIR_FWD   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BACK  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOK_SENS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_YAW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_PITCH = 3'd4;

    localparam logic [15:0] MOVE_SPEED_RST = 16'd640;
    localparam logic [15:0] LOOK_SENS_RST  = 16'd6554;
    localparam logic signed [16:0] START_YAW_RST   = -17'sd11520;
    localparam logic signed [14:0] START_PITCH_RST = 15'sd0;

    localparam int PITCH_LIMIT  = 11392;
    localparam int HALF_TURN    = 23040;
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int FAST_FACTOR  = 10;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 10188014;
    localparam int UNIT         = 16384;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_pose;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DIR_W-1:0]   move_dir;
        logic [15:0]        elapsed;
        logic signed [15:0] cursor_dx;
        logic signed [15:0] cursor_dy;
    } t_req;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic signed [16:0] angle;
    } t_trig_cmd;

    typedef struct packed {
        logic               done;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } t_trig_rsp;

    function automatic logic [23:0] atan_entry(input logic [3:0] i);
        logic [23:0] r;
        begin
            case (i)
                4'd0:  r = 24'd2949120;
                4'd1:  r = 24'd1740967;
                4'd2:  r = 24'd919879;
                4'd3:  r = 24'd466945;
                4'd4:  r = 24'd234379;
                4'd5:  r = 24'd117265;
                4'd6:  r = 24'd58666;
                4'd7:  r = 24'd29335;
                4'd8:  r = 24'd14668;
                4'd9:  r = 24'd7334;
                4'd10: r = 24'd3667;
                4'd11: r = 24'd1833;
                4'd12: r = 24'd917;
                4'd13: r = 24'd458;
                4'd14: r = 24'd229;
                4'd15: r = 24'd115;
                default: r = 24'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [15:0] clamp_unit(input logic signed [47:0] v);
        begin
            if (v > 48'sd16384) return 16'sd16384;
            if (v < -48'sd16384) return -16'sd16384;
            return v[15:0];
        end
    endfunction

    function automatic logic signed [16:0] wrap_yaw(input logic signed [18:0] v);
        begin
            if (v >= 19'sd23040) return 17'(v - 19'sd46080);
            if (v < -19'sd23040) return 17'(v + 19'sd46080);
            return v[16:0];
        end
    endfunction

    function automatic logic signed [14:0] clamp_pitch(input logic signed [25:0] v);
        begin
            if (v > 26'sd11392) return 15'sd11392;
            if (v < -26'sd11392) return -15'sd11392;
            return v[14:0];
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/fcpu_if.sv -----
// ----------------------------------------------------------------------------
// fcpu_if
// valid / ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
`default_nettype none
interface fcpu_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fly_camera_pose_update_core.sv -----
// ----------------------------------------------------------------------------
// fly_camera_pose_update_core
// camera pose keeper with cordic based orientation vectors
// ----------------------------------------------------------------------------
// latency from accept to result valid comes from the steps of each function: a move
// scales the speed, then updates the three axes; a look does two operand scalings,
// 8 yaw wrap steps, two cordic runs on one shared unit and four vector products; a
// pose reset does the cordic runs and products; an unknown function or direction
// goes straight to the result
// one request at a time: the next can be taken in the cycle after the result is accepted
// reset: registers to defaults, then a pose reload before the first request is taken
`default_nettype none
module fly_camera_pose_update_core
    import fcpu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fcpu_if.sink      i_req,
    fcpu_if.sink      i_cfg,
    fcpu_if.source    o_rsp
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TRIGY = 9'b000000010,
        S_TRIGP = 9'b000000100,
        S_MULV  = 9'b000001000,
        S_MOVE  = 9'b000010000,
        S_LOOK  = 9'b000100000,
        S_OUT   = 9'b001000000,
        S_VEL   = 9'b010000000,
        S_WRAP  = 9'b100000000
    } t_state;

    t_state r_state;
    logic [15:0] r_speed, r_sens;
    logic        r_fast;
    logic signed [16:0] r_syaw;
    logic signed [14:0] r_spitch;
    logic signed [31:0] r_pos [3];
    logic signed [16:0] r_yaw;
    logic signed [14:0] r_pitch;
    logic signed [15:0] r_fr [3];
    logic signed [15:0] r_rt [3];
    logic signed [15:0] r_up [3];
    logic signed [15:0] r_cy, r_sy;
    logic [2:0]  r_k;
    logic        r_trig_go, r_busy_trig;
    logic        r_boot;
    t_req        r_req;
    logic [35:0] r_vel;
    logic [23:0] r_ymod;
    logic        r_valid;
    t_pose       r_out;

    t_trig_cmd trig_cmd;
    t_trig_rsp trig_rsp;

    fcpu_trig u_trig (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(trig_cmd), .o_rsp(trig_rsp));

    // shared multiplier
    logic signed [24:0] mul_a;
    logic signed [36:0] mul_b;
    logic signed [61:0] mul_p;
    logic signed [15:0] sel_vec;
    logic signed [47:0] d, upd, ld;
    logic signed [24:0] yaw_sum;
    logic signed [25:0] pitch_sum;
    logic [23:0] wrap_sub, wrap_rem;
    logic        plus;

    always_comb begin
        case (r_req.move_dir)
            DIR_FWD, DIR_BACK:  sel_vec = r_fr[r_k[1:0]];
            DIR_LEFT, DIR_RIGHT: sel_vec = r_rt[r_k[1:0]];
            default:            sel_vec = r_up[r_k[1:0]];
        endcase
        plus = r_req.move_dir == DIR_FWD || r_req.move_dir == DIR_RIGHT ||
               r_req.move_dir == DIR_UP;
        mul_a = 25'(sel_vec);
        mul_b = $signed({1'b0, r_vel});
        case (r_state)
            S_VEL: begin
                mul_a = $signed({9'd0, r_speed});
                mul_b = $signed({21'd0, r_req.elapsed});
            end
            S_LOOK: begin
                mul_a = r_k[0] ? 25'(r_req.cursor_dy) : 25'(r_req.cursor_dx);
                mul_b = $signed({21'd0, r_sens});
            end
            S_MULV: begin
                mul_a = (r_k == 3'd0 || r_k == 3'd2) ? 25'(r_cy) : 25'(r_sy);
                mul_b = (r_k < 3'd2) ? 37'(trig_rsp.cos_v) : 37'(trig_rsp.sin_v);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
        d   = 48'((mul_p + 62'sd2097152) >>> 22);
        upd = plus ? 48'(r_pos[r_k[1:0]]) + d : 48'(r_pos[r_k[1:0]]) - d;
        ld  = 48'((mul_p + 62'sd256) >>> 9);
        // offset by half a turn plus 128 turns so the sum stays positive
        yaw_sum = 25'(r_yaw) + 25'(ld) + 25'(HALF_TURN + FULL_TURN * 128);
        pitch_sum = 26'(r_pitch) - 26'(ld);
        // restoring reduction by 128, 64, ... 1 turns
        wrap_sub = 24'(FULL_TURN) << (3'd7 - r_k);
        wrap_rem = (r_ymod >= wrap_sub) ? r_ymod - wrap_sub : r_ymod;
        trig_cmd.start = r_trig_go;
        trig_cmd.angle = (r_state == S_TRIGP) ? 17'(r_pitch) : r_yaw;
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_valid && !r_busy_trig;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= MOVE_SPEED_RST;
            r_sens  <= LOOK_SENS_RST;
            r_fast  <= 1'b0;
            r_syaw  <= START_YAW_RST;
            r_spitch <= START_PITCH_RST;
            r_state <= S_TRIGY;
            r_trig_go <= 1'b1;
            r_busy_trig <= 1'b1;
            r_boot <= 1'b1;
            r_valid <= 1'b0;
            r_k <= '0;
            r_req.func <= FUNC_RESET;
            r_pos[0] <= '0; r_pos[1] <= '0; r_pos[2] <= '0;
            r_yaw <= wrap_yaw(19'(START_YAW_RST));
            r_pitch <= clamp_pitch(26'(START_PITCH_RST));
        end else begin
            r_trig_go <= 1'b0;
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_MOVE_SPEED:  r_speed <= i_cfg.data.data[15:0];
                    REG_LOOK_SENS:   r_sens  <= i_cfg.data.data[15:0];
                    REG_FAST_MODE:   r_fast  <= i_cfg.data.data[0];
                    REG_START_YAW:   r_syaw  <= $signed(i_cfg.data.data[16:0]);
                    REG_START_PITCH: r_spitch <= $signed(i_cfg.data.data[14:0]);
                    default: ;
                endcase
            end
            if (o_rsp.valid && o_rsp.ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_k <= '0;
                        case (i_req.data.func)
                            FUNC_RESET: begin
                                r_pos[0] <= '0; r_pos[1] <= '0; r_pos[2] <= '0;
                                r_yaw <= wrap_yaw(19'(r_syaw));
                                r_pitch <= clamp_pitch(26'(r_spitch));
                                r_trig_go <= 1'b1;
                                r_busy_trig <= 1'b1;
                                r_state <= S_TRIGY;
                            end
                            FUNC_MOVE: r_state <= (i_req.data.move_dir <= DIR_UP) ?
                                                  S_VEL : S_OUT;
                            FUNC_LOOK: r_state <= S_LOOK;
                            default:   r_state <= S_OUT;
                        endcase
                    end
                end
                S_VEL: begin
                    // times ten as two shifts
                    r_vel <= r_fast ? ({4'd0, mul_p[31:0]} << 3) + ({4'd0, mul_p[31:0]} << 1)
                                    : {4'd0, mul_p[31:0]};
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    if (upd > 48'sh7fffffff) r_pos[r_k[1:0]] <= 32'sh7fffffff;
                    else if (upd < -48'sh80000000) r_pos[r_k[1:0]] <= 32'sh80000000;
                    else r_pos[r_k[1:0]] <= upd[31:0];
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd2) r_state <= S_OUT;
                end
                S_LOOK: begin
                    if (r_k == 3'd0) begin
                        r_ymod <= yaw_sum[23:0];
                        r_k <= 3'd1;
                    end else begin
                        r_pitch <= clamp_pitch(pitch_sum);
                        r_k <= '0;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_ymod <= wrap_rem;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_yaw <= 17'($signed({1'b0, wrap_rem}) - 25'(HALF_TURN));
                        r_trig_go <= 1'b1;
                        r_busy_trig <= 1'b1;
                        r_state <= S_TRIGY;
                    end
                end
                S_TRIGY: begin
                    if (trig_rsp.done) begin
                        r_cy <= trig_rsp.cos_v;
                        r_sy <= trig_rsp.sin_v;
                        r_trig_go <= 1'b1;
                        r_state <= S_TRIGP;
                    end
                end
                S_TRIGP: begin
                    if (trig_rsp.done) begin
                        r_k <= '0;
                        r_fr[1] <= trig_rsp.sin_v;
                        r_up[1] <= trig_rsp.cos_v;
                        r_rt[0] <= clamp_unit(-48'(r_sy));
                        r_rt[1] <= '0;
                        r_rt[2] <= r_cy;
                        r_state <= S_MULV;
                    end
                end
                S_MULV: begin
                    // trig output holds until the next start
                    r_k <= r_k + 3'd1;
                    case (r_k)
                        3'd0: r_fr[0] <= clamp_unit((48'(mul_p) + 48'sd8192) >>> 14);
                        3'd1: r_fr[2] <= clamp_unit((48'(mul_p) + 48'sd8192) >>> 14);
                        3'd2: r_up[0] <= clamp_unit(-48'(clamp_unit(
                                  (48'(mul_p) + 48'sd8192) >>> 14)));
                        default: r_up[2] <= clamp_unit(-48'(clamp_unit(
                                  (48'(mul_p) + 48'sd8192) >>> 14)));
                    endcase
                    if (r_k == 3'd3) begin
                        r_busy_trig <= 1'b0;
                        r_boot <= 1'b0;
                        // power-on reload returns no result
                        r_state <= r_boot ? S_IDLE : S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_out <= '{r_pos[0], r_pos[1], r_pos[2], r_fr[0], r_fr[1], r_fr[2],
                               r_rt[0], r_rt[1], r_rt[2], r_up[0], r_up[1], r_up[2]};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_rsp.ready |=> r_valid) else $error("result dropped");
    a_busy_noaccept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.ready) else $error("accept while busy");
    a_right_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && !r_busy_trig |-> r_rt[1] == 16'sd0) else $error("right y");
endmodule
`default_nettype wire

// ----- rtl/fcpu_trig.sv -----
// ----------------------------------------------------------------------------
// fcpu_trig
// iterative cordic sine and cosine, one rotation step per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fcpu_trig
    import fcpu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_trig_cmd i_cmd,
    output t_trig_rsp  o_rsp
);
    logic signed [27:0] r_x, r_y;
    logic signed [27:0] r_z;
    logic [3:0]         r_step;
    logic               r_busy, r_neg, r_done;
    logic signed [15:0] r_cos, r_sin;

    logic signed [16:0] fold_a;
    logic               fold_neg;
    logic signed [27:0] xs, ys, tab, xf, yf;
    logic signed [27:0] n_x, n_y, n_z;
    logic signed [27:0] rx, ry;

    always_comb begin
        fold_a = i_cmd.angle;
        fold_neg = 1'b0;
        if (i_cmd.angle > 17'sd11520) begin
            fold_a = i_cmd.angle - 17'sd23040;
            fold_neg = 1'b1;
        end else if (i_cmd.angle < -17'sd11520) begin
            fold_a = i_cmd.angle + 17'sd23040;
            fold_neg = 1'b1;
        end
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
        tab = 28'(atan_entry(r_step));
        if (r_z >= 0) begin
            n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - tab;
        end else begin
            n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + tab;
        end
        xf = r_neg ? -n_x : n_x;
        yf = r_neg ? -n_y : n_y;
        rx = (xf + 28'sd512) >>> 10;
        ry = (yf + 28'sd512) >>> 10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_neg  <= fold_neg;
                r_x    <= 28'sd10188014;
                r_y    <= '0;
                r_z    <= 28'(fold_a) <<< 9;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_step <= r_step + 4'd1;
                if (r_step == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_cos  <= clamp_unit(48'(rx));
                    r_sin  <= clamp_unit(48'(ry));
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.cos_v = r_cos;
    assign o_rsp.sin_v = r_sin;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_step != 4'd0 |-> !i_cmd.start) else $error("trig restarted");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cos <= 16'sd16384 && r_cos >= -16'sd16384) else $error("cos range");
endmodule
`default_nettype wire

// ----- sim/fcpu_tb_if.sv -----
// ----------------------------------------------------------------------------
// fcpu_tb_if
// (interfaces come from rtl/fcpu_if.sv; this file holds the pose predictor)
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module fly_camera_pose_update_core_chk
    import fcpu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fcpu_if.source    i_req,
    fcpu_if.source    i_cfg,
    fcpu_if.sink      o_rsp,
    output int        o_fail_count,
    output int        o_pending
);
    longint cam_pos[3];
    longint yaw_q, pitch_q;
    longint fwd[3], rgt[3], upv[3];
    longint spd, sens, fast, syaw, spitch;
    t_pose  pose_q[$];

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint yaw_wrap(longint v);
        longint r;
        r = (v + HALF_TURN) % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        return r - HALF_TURN;
    endfunction

    function automatic longint pitch_clamp(longint v);
        if (v > PITCH_LIMIT) return PITCH_LIMIT;
        if (v < -PITCH_LIMIT) return -PITCH_LIMIT;
        return v;
    endfunction

    task automatic cordic_sincos(input longint ang, output longint c, output longint s);
        longint atn[16] = '{2949120, 1740967, 919879, 466945, 234379, 117265, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        longint a, x, y, z, xs, ys;
        bit     flip;
        a = ang;
        flip = 0;
        x = CORDIC_GAIN;
        y = 0;
        if (a > QUARTER_TURN) begin
            a -= 2 * QUARTER_TURN;
            flip = 1;
        end else if (a < -QUARTER_TURN) begin
            a += 2 * QUARTER_TURN;
            flip = 1;
        end
        z = a * 512;
        for (int i = 0; i < 16; i++) begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atn[i];
            end else begin
                x += ys; y -= xs; z += atn[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = unit_clamp(rnd_shift(x, 10));
        s = unit_clamp(rnd_shift(y, 10));
    endtask

    function automatic longint umul(longint a, longint b);
        return unit_clamp(rnd_shift(a * b, 14));
    endfunction

    task automatic refresh_axes();
        longint cy, sy, cp, sp;
        cordic_sincos(yaw_q, cy, sy);
        cordic_sincos(pitch_q, cp, sp);
        fwd[0] = umul(cy, cp); fwd[1] = sp; fwd[2] = umul(sy, cp);
        rgt[0] = unit_clamp(-sy); rgt[1] = 0; rgt[2] = cy;
        upv[0] = unit_clamp(-umul(cy, sp)); upv[1] = cp; upv[2] = unit_clamp(-umul(sy, sp));
    endtask

    task automatic reload_pose();
        cam_pos[0] = 0; cam_pos[1] = 0; cam_pos[2] = 0;
        yaw_q = yaw_wrap(syaw);
        pitch_q = pitch_clamp(spitch);
        refresh_axes();
    endtask

    task automatic apply_request(input t_req r);
        longint vel, d, dx, dy;
        bit     plus;
        t_pose  p;
        if (r.func == FUNC_RESET) begin
            reload_pose();
        end else if (r.func == FUNC_MOVE && r.move_dir <= DIR_UP) begin
            vel = spd * (fast ? FAST_FACTOR : 1) * longint'(r.elapsed);
            plus = (r.move_dir == DIR_FWD || r.move_dir == DIR_RIGHT || r.move_dir == DIR_UP);
            for (int k = 0; k < 3; k++) begin
                if (r.move_dir <= DIR_BACK) d = rnd_shift(fwd[k] * vel, 22);
                else if (r.move_dir <= DIR_RIGHT) d = rnd_shift(rgt[k] * vel, 22);
                else d = rnd_shift(upv[k] * vel, 22);
                cam_pos[k] += plus ? d : -d;
                if (cam_pos[k] > 64'sd2147483647) cam_pos[k] = 64'sd2147483647;
                if (cam_pos[k] < -64'sd2147483648) cam_pos[k] = -64'sd2147483648;
            end
        end else if (r.func == FUNC_LOOK) begin
            dx = rnd_shift(longint'(r.cursor_dx) * sens, 9);
            dy = rnd_shift(longint'(r.cursor_dy) * sens, 9);
            yaw_q = yaw_wrap(yaw_q + dx);
            pitch_q = pitch_clamp(pitch_q - dy);
            refresh_axes();
        end
        p.pos_x = 32'(cam_pos[0]); p.pos_y = 32'(cam_pos[1]); p.pos_z = 32'(cam_pos[2]);
        p.front_x = 16'(fwd[0]); p.front_y = 16'(fwd[1]); p.front_z = 16'(fwd[2]);
        p.right_x = 16'(rgt[0]); p.right_y = 16'(rgt[1]); p.right_z = 16'(rgt[2]);
        p.up_x = 16'(upv[0]); p.up_y = 16'(upv[1]); p.up_z = 16'(upv[2]);
        pose_q.push_back(p);
    endtask

    task automatic chk(input string nm, input longint e, input longint a);
        if (e != a) begin
            $error("%s expected %0d actual %0d", nm, e, a);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_pose e, a;
        if (!i_rst_n) begin
            spd = longint'(MOVE_SPEED_RST); sens = longint'(LOOK_SENS_RST); fast = 0;
            syaw = longint'(START_YAW_RST); spitch = longint'(START_PITCH_RST);
            reload_pose();
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                a = o_rsp.data;
                if (pose_q.size() == 0) begin
                    $error("unexpected response");
                    o_fail_count++;
                end else begin
                    e = pose_q.pop_front();
                    chk("pos_x", e.pos_x, a.pos_x);
                    chk("pos_y", e.pos_y, a.pos_y);
                    chk("pos_z", e.pos_z, a.pos_z);
                    chk("front_x", e.front_x, a.front_x);
                    chk("front_y", e.front_y, a.front_y);
                    chk("front_z", e.front_z, a.front_z);
                    chk("right_x", e.right_x, a.right_x);
                    chk("right_y", e.right_y, a.right_y);
                    chk("right_z", e.right_z, a.right_z);
                    chk("up_x", e.up_x, a.up_x);
                    chk("up_y", e.up_y, a.up_y);
                    chk("up_z", e.up_z, a.up_z);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    REG_MOVE_SPEED:  spd = longint'(i_cfg.data.data[15:0]);
                    REG_LOOK_SENS:   sens = longint'(i_cfg.data.data[15:0]);
                    REG_FAST_MODE:   fast = longint'(i_cfg.data.data[0]);
                    REG_START_YAW:   syaw = longint'($signed(i_cfg.data.data[16:0]));
                    REG_START_PITCH: spitch = longint'($signed(i_cfg.data.data[14:0]));
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) apply_request(i_req.data);
        end
        o_pending = pose_q.size();
    end
endmodule
`default_nettype wire

// ----- sim/fly_camera_pose_update_core_tb.sv -----
// ----------------------------------------------------------------------------
// fly_camera_pose_update_core_tb
// drives directed and random camera requests and register settings in
// bursts with a stalling receiver; the checker predicts every pose
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module fly_camera_pose_update_core_tb;
    import fcpu_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [DIR_W-1:0]     DIR_UNUSED  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_count, pending, cycle_count;
    bit   long_hold = 0;
    bit   hold_done = 0;

    fcpu_if #(.T(t_req))  req_ch ();
    fcpu_if #(.T(t_cfg))  cfg_ch ();
    fcpu_if #(.T(t_pose)) rsp_ch ();

    fly_camera_pose_update_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    fly_camera_pose_update_core_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch.source),
        .i_cfg       (cfg_ch.source),
        .o_rsp       (rsp_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 0; req_ch.data = '0;
        cfg_ch.valid = 0; cfg_ch.data = '0;
        rsp_ch.ready = 0;
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        int mode;
        if (long_hold && !hold_done) begin
            rsp_ch.ready <= 0;
            repeat (300) @(posedge i_clk);
            hold_done = 1;
        end else begin
            mode = (cycle_count / 500) % 3;
            if (mode == 0) rsp_ch.ready <= 1;
            else if (mode == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            else rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("fly_camera_pose_update_core_tb NOT OK");
            $finish;
        end
    end

    task automatic send_req(input t_req r);
        req_ch.data <= r;
        req_ch.valid <= 1;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic idle_req();
        req_ch.valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_ch.data <= '{index: idx, data: v};
        cfg_ch.valid <= 1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_req make_req(logic [1:0] f, logic [2:0] d, logic [15:0] el,
                                      logic [15:0] dx, logic [15:0] dy);
        t_req r;
        r.func = f; r.move_dir = d; r.elapsed = el; r.cursor_dx = dx; r.cursor_dy = dy;
        return r;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   k;
        k = $urandom_range(0, 99);
        if (k < 5) r.func = FUNC_RESET;
        else if (k < 50) r.func = FUNC_MOVE;
        else if (k < 97) r.func = FUNC_LOOK;
        else r.func = FUNC_UNUSED;
        r.move_dir = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
        r.elapsed = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        if ($urandom_range(0, 9) == 0) begin
            r.cursor_dx = 16'($urandom); r.cursor_dy = 16'($urandom);
        end else begin
            r.cursor_dx = 16'($signed(10'($urandom)));
            r.cursor_dy = 16'($signed(10'($urandom)));
        end
        return r;
    endfunction

    task automatic random_phase(input int n);
        int left;
        left = n;
        while (left > 0) begin
            repeat ($urandom_range(1, 20)) begin
                if (left > 0) begin
                    send_req(rand_req());
                    left--;
                end
            end
            if ($urandom_range(0, 2) != 0) idle_req();
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every func and direction, field extremes
        send_req(make_req(FUNC_RESET, DIR_FWD, 16'd0, 16'd0, 16'd0));
        for (int d = 0; d < 8; d++)
            send_req(make_req(FUNC_MOVE, 3'(d), 16'hFFFF, 16'd0, 16'd0));
        send_req(make_req(FUNC_LOOK, DIR_FWD, 16'd0, 16'h7FFF, 16'h8000));
        send_req(make_req(FUNC_LOOK, DIR_FWD, 16'd0, 16'h8000, 16'h7FFF));
        send_req(make_req(FUNC_LOOK, DIR_FWD, 16'd0, 16'd100, 16'hFF9C));
        for (int d = 0; d < 6; d++)
            send_req(make_req(FUNC_MOVE, 3'(d), 16'd1, 16'd0, 16'd0));
        send_req(make_req(FUNC_UNUSED, DIR_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(FUNC_RESET, DIR_FWD, 16'd0, 16'd0, 16'd0));
        drain();

        // extreme settings, saturating movement, out of range starts
        write_reg(REG_MOVE_SPEED, 17'hFFFF);
        write_reg(REG_FAST_MODE, 17'd1);
        write_reg(REG_LOOK_SENS, 17'hFFFF);
        write_reg(REG_START_YAW, 17'h1FFFF & 17'sd46080);
        write_reg(REG_START_PITCH, 17'h7FFF & 17'sd16383);
        write_reg(REG_UNUSED, 17'h1FFFF);
        send_req(make_req(FUNC_RESET, DIR_FWD, 16'd0, 16'd0, 16'd0));
        for (int i = 0; i < 4; i++)
            send_req(make_req(FUNC_MOVE, DIR_UP, 16'hFFFF, 16'd0, 16'd0));
        for (int i = 0; i < 4; i++)
            send_req(make_req(FUNC_MOVE, DIR_DOWN, 16'hFFFF, 16'd0, 16'd0));
        random_phase(400);

        write_reg(REG_MOVE_SPEED, 17'd0);
        write_reg(REG_LOOK_SENS, 17'd0);
        write_reg(REG_FAST_MODE, 17'd0);
        write_reg(REG_START_YAW, 17'h10000);
        write_reg(REG_START_PITCH, 17'h4000);
        random_phase(200);

        write_reg(REG_MOVE_SPEED, 17'd640);
        write_reg(REG_LOOK_SENS, 17'd6554);
        write_reg(REG_START_YAW, -17'sd46080);
        write_reg(REG_START_PITCH, -17'sd11392);
        long_hold = 1;
        random_phase(500);

        write_reg(REG_MOVE_SPEED, 17'($urandom));
        write_reg(REG_LOOK_SENS, 17'($urandom));
        write_reg(REG_FAST_MODE, 17'd1);
        write_reg(REG_START_YAW, 17'($urandom_range(0, 46080)));
        write_reg(REG_START_PITCH, 17'($urandom));
        random_phase(500);

        if (fail_count == 0) $display("fly_camera_pose_update_core_tb OK");
        else $display("fly_camera_pose_update_core_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/fcpu_pkg.sv
rtl/fcpu_if.sv
rtl/fcpu_trig.sv
rtl/fly_camera_pose_update_core.sv
sim/fcpu_tb_if.sv
sim/fly_camera_pose_update_core_tb.sv
